### src/lrs_pkg.sv
`default_nettype none
package lrs_pkg;

  localparam int ROW_BITS          = 64;
  localparam int ROW_CELLS_DEFAULT = 64;
  localparam int COLS_W            = 7;
  localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_cells;
    logic                final_row;
  } row_beat_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] next_cells;
    logic                frame_done;
  } result_beat_t;

  typedef struct packed {
    logic upper;
    logic middle;
    logic row;
  } lrs_nbr_t;

  typedef struct packed {
    logic first;
    logic second;
  } lrs_push_t;

endpackage
`default_nettype wire

### src/life_rule_row_stencil.sv
// Channel   Direction  Handshake                Payload
// row       in         row_valid / row_stall    row_beat_t    (row_cells, final_row)
// result    out        result_valid / result_stall  result_beat_t (next_cells, frame_done)
// cfg       in         cfg_we                   cfg_wdata     (cols_in_use)
//
// One row beat is taken per cycle unless row_stall is high; its results are queued.
// A bottom row after a held row yields two result beats, drained one per unstalled cycle.
// The four-entry output queue stalls the row channel when fewer than two entries are free.
// Reset clears the held-row flag and the queue; cols_in_use returns to 64.
`default_nettype none
module life_rule_row_stencil
  import lrs_pkg::*;
#(
  parameter int ROW_CELLS = ROW_CELLS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              row_valid,
  output logic                   row_stall,
  input  wire row_beat_t         row_data,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_beat_t           result_data,
  input  wire logic              cfg_we,
  input  wire logic [COLS_W-1:0] cfg_wdata
);

  logic [COLS_W-1:0]   cols_in_use;
  logic                held;
  logic                accept;
  logic                room;
  logic [ROW_BITS-1:0] next_a;
  logic [ROW_BITS-1:0] next_b;
  lrs_nbr_t            nbr [ROW_CELLS];
  lrs_push_t           push;
  result_beat_t        first_data;
  result_beat_t        second_data;

  assign row_stall = ~room;
  assign accept    = row_valid & room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_RESET;
      held        <= 1'b0;
    end else begin
      if (cfg_we) begin
        cols_in_use <= cfg_wdata;
      end
      if (accept) begin
        held <= ~row_data.final_row;
      end
    end
  end

  for (genvar c = 0; c < ROW_CELLS; c++) begin : g_col
    logic     live;
    lrs_nbr_t left;
    lrs_nbr_t right;

    assign live  = (COLS_W'(c) < cols_in_use);
    assign left  = (c == 0) ? '0 : nbr[(c == 0) ? 0 : c - 1];
    assign right = (c == ROW_CELLS - 1) ? '0 : nbr[(c == ROW_CELLS - 1) ? c : c + 1];

    lrs_cell u_cell (
      .clk     (clk),
      .accept  (accept),
      .held    (held),
      .live    (live),
      .row_bit (row_data.row_cells[c] & live),
      .left    (left),
      .right   (right),
      .here    (nbr[c]),
      .next_a  (next_a[c]),
      .next_b  (next_b[c])
    );
  end

  if (ROW_CELLS < ROW_BITS) begin : g_dead_cols
    assign next_a[ROW_BITS-1:ROW_CELLS] = '0;
    assign next_b[ROW_BITS-1:ROW_CELLS] = '0;
  end

  always_comb begin
    push.first  = accept & (held | row_data.final_row);
    push.second = accept & held & row_data.final_row;

    first_data.next_cells  = held ? next_a : next_b;
    first_data.frame_done  = ~held;
    second_data.next_cells = next_b;
    second_data.frame_done = 1'b1;
  end

  lrs_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .first_data   (first_data),
    .second_data  (second_data),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
`default_nettype wire

### src/lrs_cell.sv
`default_nettype none
module lrs_cell
  import lrs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     accept,
  input  wire logic     held,
  input  wire logic     live,
  input  wire logic     row_bit,
  input  wire lrs_nbr_t left,
  input  wire lrs_nbr_t right,
  output lrs_nbr_t      here,
  output logic          next_a,
  output logic          next_b
);

  logic       upper;
  logic       middle;
  logic [3:0] count_a;
  logic [3:0] count_b;
  logic [3:0] above_b;

  always_ff @(posedge clk) begin
    if (accept) begin
      upper  <= held ? middle : 1'b0;
      middle <= row_bit;
    end
  end

  always_comb begin
    here.upper  = upper & live;
    here.middle = middle & live;
    here.row    = row_bit;
  end

  always_comb begin
    count_a = 4'(left.upper) + 4'(here.upper) + 4'(right.upper)
            + 4'(left.row) + 4'(here.row) + 4'(right.row)
            + 4'(left.middle) + 4'(right.middle);
    next_a  = live & ((count_a == 4'd3) | ((count_a == 4'd2) & here.middle));

    above_b = held ? (4'(left.middle) + 4'(here.middle) + 4'(right.middle)) : 4'd0;
    count_b = above_b + 4'(left.row) + 4'(right.row);
    next_b  = live & ((count_b == 4'd3) | ((count_b == 4'd2) & here.row));
  end

endmodule
`default_nettype wire

### src/lrs_out_queue.sv
`default_nettype none
module lrs_out_queue
  import lrs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire lrs_push_t    push,
  input  wire result_beat_t first_data,
  input  wire result_beat_t second_data,
  output logic              room,
  output logic              result_valid,
  input  wire logic         result_stall,
  output result_beat_t      result_data
);

  result_beat_t           entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] head;
  logic [QUEUE_PTR_W-1:0] tail;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_PTR_W-1:0] tail_next;
  logic [QUEUE_CNT_W-1:0] count_next;
  logic                   pop;

  assign pop          = result_valid & ~result_stall;
  assign result_valid = (count != '0);
  assign result_data  = entries[head];
  assign room         = (count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    tail_next  = tail + QUEUE_PTR_W'(push.first) + QUEUE_PTR_W'(push.second);
    count_next = count + QUEUE_CNT_W'(push.first) + QUEUE_CNT_W'(push.second)
               - QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[tail] <= first_data;
    end
    if (push.second) begin
      entries[tail + QUEUE_PTR_W'(1)] <= second_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail_next;
      count <= count_next;
      if (pop) begin
        head <= head + QUEUE_PTR_W'(1);
      end
    end
  end

endmodule
`default_nettype wire
